FILE: rtl/pcrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcrg_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned CUR_W   = 18;
  localparam int unsigned RUN_W   = 16;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLANKING = 2'd0,
    REG_OC_LIMIT = 2'd1,
    REG_INV_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_A    = 2'd1,
    PH_B    = 2'd2,
    PH_C    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ACT_USE          = 2'd0,
    ACT_HOLD         = 2'd1,
    ACT_TRIP_INVALID = 2'd2,
    ACT_TRIP_OC      = 2'd3
  } action_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic signed [CUR_W-1:0] cur_a;
    logic signed [CUR_W-1:0] cur_b;
    logic signed [CUR_W-1:0] cur_c;
    logic [TICK_W-1:0]       mrg_a;
    logic [TICK_W-1:0]       mrg_b;
    logic [TICK_W-1:0]       mrg_c;
    logic [2:0]              mask;
    phase_t                  phase;
    logic                    ok;
    logic                    oc;
  } frame_t;

  typedef struct packed {
    logic [TICK_W-1:0] blanking;
    logic [RUN_W-1:0]  oc_max;
    logic [RUN_W-1:0]  inv_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/pcrg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcrg_front (
  input  wire logic [pcrg_pkg::TICK_W-1:0]        blanking,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        duty_a,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        duty_b,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        duty_c,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        sample_time,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]  sample_a,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]  sample_b,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]  sample_c,
  input  wire logic                               overcurrent,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  output      logic                               push,
  input  wire logic                               q_full,
  output      pcrg_pkg::frame_t                   frame
);

  // a word is taken whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  pcrg_classify u_classify (
    .blanking    (blanking),
    .duty_a      (duty_a),
    .duty_b      (duty_b),
    .duty_c      (duty_c),
    .sample_time (sample_time),
    .sample_a    (sample_a),
    .sample_b    (sample_b),
    .sample_c    (sample_c),
    .overcurrent (overcurrent),
    .frame       (frame)
  );

endmodule

`default_nettype wire

FILE: rtl/pcrg_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module pcrg_classify (
  input  wire logic [pcrg_pkg::TICK_W-1:0]        blanking,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        duty_a,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        duty_b,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        duty_c,
  input  wire logic [pcrg_pkg::TICK_W-1:0]        sample_time,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]  sample_a,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]  sample_b,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]  sample_c,
  input  wire logic                               overcurrent,
  output      pcrg_pkg::frame_t                   frame
);

  localparam int unsigned EXT = pcrg_pkg::CUR_W - pcrg_pkg::RAW_W;

  logic [pcrg_pkg::TICK_W-1:0]        ma, mb, mc;
  logic [2:0]                         mask;
  logic [pcrg_pkg::TICK_W-1:0]        least;
  pcrg_pkg::phase_t                   phase;
  logic                               ok;
  logic signed [pcrg_pkg::CUR_W-1:0]  ia, ib, ic;

  always_comb begin
    ma = (sample_time > duty_a) ? pcrg_pkg::TICK_W'(sample_time - duty_a) : '0;
    mb = (sample_time > duty_b) ? pcrg_pkg::TICK_W'(sample_time - duty_b) : '0;
    mc = (sample_time > duty_c) ? pcrg_pkg::TICK_W'(sample_time - duty_c) : '0;
    mask = {mc >= blanking, mb >= blanking, ma >= blanking};
    ok = (mask[0] && mask[1]) || (mask[0] && mask[2]) || (mask[1] && mask[2]);
  end

  // pick the phase to rebuild; on ties C wins over B, B over A
  always_comb begin
    least = mc;
    phase = pcrg_pkg::PH_NONE;
    if (mask == 3'b111) begin
      phase = pcrg_pkg::PH_C;
      if (mb < least) begin
        least = mb;
        phase = pcrg_pkg::PH_B;
      end
      if (ma < least) begin
        phase = pcrg_pkg::PH_A;
      end
    end else if (ok) begin
      if (!mask[0]) begin
        phase = pcrg_pkg::PH_A;
      end else if (!mask[1]) begin
        phase = pcrg_pkg::PH_B;
      end else begin
        phase = pcrg_pkg::PH_C;
      end
    end
  end

  always_comb begin
    ia = {{EXT{sample_a[pcrg_pkg::RAW_W-1]}}, sample_a};
    ib = {{EXT{sample_b[pcrg_pkg::RAW_W-1]}}, sample_b};
    ic = {{EXT{sample_c[pcrg_pkg::RAW_W-1]}}, sample_c};
    if (!ok) begin
      ia = '0;
      ib = '0;
      ic = '0;
    end else begin
      case (phase)
        pcrg_pkg::PH_A: ia = -(ib + ic);
        pcrg_pkg::PH_B: ib = -(ia + ic);
        default:        ic = -(ia + ib);
      endcase
    end
  end

  always_comb begin
    frame.cur_a = ia;
    frame.cur_b = ib;
    frame.cur_c = ic;
    frame.mrg_a = ma;
    frame.mrg_b = mb;
    frame.mrg_c = mc;
    frame.mask  = mask;
    frame.phase = phase;
    frame.ok    = ok;
    frame.oc    = overcurrent;
  end

endmodule

`default_nettype wire

FILE: rtl/pcrg_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pcrg_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pcrg_pkg::frame_t wr_frame,
  output      logic             full,
  output      logic             not_empty,
  input  wire logic             pop,
  output      pcrg_pkg::frame_t rd_frame
);

  pcrg_pkg::frame_t                  slots [pcrg_pkg::QDEPTH];
  logic [pcrg_pkg::QPTR_W-1:0]       wr_ptr;
  logic [pcrg_pkg::QPTR_W-1:0]       rd_ptr;
  logic [pcrg_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  assign full      = (count == pcrg_pkg::QCNT_W'(pcrg_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_frame  = slots[rd_ptr];

  function automatic logic [pcrg_pkg::QPTR_W-1:0] bump(input logic [pcrg_pkg::QPTR_W-1:0] p);
    logic [pcrg_pkg::QPTR_W-1:0] r;
    if (p == pcrg_pkg::QPTR_W'(pcrg_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_frame;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcrg_guard.sv
`timescale 1ns / 1ps
`default_nettype none

module pcrg_guard (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [pcrg_pkg::RUN_W-1:0]           oc_max,
  input  wire logic [pcrg_pkg::RUN_W-1:0]           inv_limit,
  input  wire logic                                 q_not_empty,
  input  wire pcrg_pkg::frame_t                     q_frame,
  output      logic                                 pop,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [pcrg_pkg::CUR_W-1:0]    current_a,
  output      logic signed [pcrg_pkg::CUR_W-1:0]    current_b,
  output      logic signed [pcrg_pkg::CUR_W-1:0]    current_c,
  output      logic [pcrg_pkg::TICK_W-1:0]          edge_gap_a,
  output      logic [pcrg_pkg::TICK_W-1:0]          edge_gap_b,
  output      logic [pcrg_pkg::TICK_W-1:0]          edge_gap_c,
  output      logic [2:0]                           ok_mask,
  output      logic [1:0]                           rebuilt_phase,
  output      logic                                 frame_ok,
  output      logic [1:0]                           guard_action,
  output      logic [pcrg_pkg::TOTAL_W-1:0]         invalid_frames
);

  logic [pcrg_pkg::RUN_W-1:0]    oc_run, oc_run_next;
  logic [pcrg_pkg::RUN_W-1:0]    inv_run, inv_run_next;
  logic [pcrg_pkg::TOTAL_W-1:0]  inv_total, inv_total_next;
  pcrg_pkg::action_t             action_next;

  assign pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    oc_run_next    = oc_run;
    inv_run_next   = inv_run;
    inv_total_next = inv_total;
    action_next    = pcrg_pkg::ACT_USE;
    if (!q_frame.ok) begin
      oc_run_next    = '0;
      inv_total_next = inv_total + 1'b1;
      inv_run_next   = (&inv_run) ? inv_run : inv_run + 1'b1;
      action_next    = (inv_run_next >= inv_limit) ? pcrg_pkg::ACT_TRIP_INVALID
                                                   : pcrg_pkg::ACT_HOLD;
    end else begin
      inv_run_next = '0;
      if (!q_frame.oc) begin
        oc_run_next = '0;
      end else begin
        oc_run_next = (&oc_run) ? oc_run : oc_run + 1'b1;
        if (oc_run_next >= oc_max) begin
          action_next = pcrg_pkg::ACT_TRIP_OC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oc_run    <= '0;
      inv_run   <= '0;
      inv_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        oc_run    <= oc_run_next;
        inv_run   <= inv_run_next;
        inv_total <= inv_total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      current_a      <= q_frame.cur_a;
      current_b      <= q_frame.cur_b;
      current_c      <= q_frame.cur_c;
      edge_gap_a     <= q_frame.mrg_a;
      edge_gap_b     <= q_frame.mrg_b;
      edge_gap_c     <= q_frame.mrg_c;
      ok_mask        <= q_frame.mask;
      rebuilt_phase  <= q_frame.phase;
      frame_ok       <= q_frame.ok;
      guard_action   <= action_next;
      invalid_frames <= inv_total_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/phase_current_rebuild_guard_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-shunt phase current rebuild with a sampling guard. One word per
// PWM frame is taken on the in channel; each gives exactly one result word
// on the out channel, in order. A new word can be taken every clock cycle
// while the queue has room: the front classifies a word in the cycle it is
// taken and writes it into a two-entry queue, and the guard stage pulls one
// word per cycle, while its output register is free or being read, from the
// queue into that register; the in side keeps running while up to three
// results wait for out_ready. Register writes (cfg_index 0 blanking, 1
// overcurrent limit, 2 invalid limit, others ignored) are always taken and
// must only be issued while no frame is in flight.
module phase_current_rebuild_guard_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [pcrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pcrg_pkg::RUN_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic [pcrg_pkg::TICK_W-1:0]          duty_a,
  input  wire logic [pcrg_pkg::TICK_W-1:0]          duty_b,
  input  wire logic [pcrg_pkg::TICK_W-1:0]          duty_c,
  input  wire logic [pcrg_pkg::TICK_W-1:0]          sample_time,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]    sample_a,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]    sample_b,
  input  wire logic signed [pcrg_pkg::RAW_W-1:0]    sample_c,
  input  wire logic                                 overcurrent,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [pcrg_pkg::CUR_W-1:0]    current_a,
  output      logic signed [pcrg_pkg::CUR_W-1:0]    current_b,
  output      logic signed [pcrg_pkg::CUR_W-1:0]    current_c,
  output      logic [pcrg_pkg::TICK_W-1:0]          edge_gap_a,
  output      logic [pcrg_pkg::TICK_W-1:0]          edge_gap_b,
  output      logic [pcrg_pkg::TICK_W-1:0]          edge_gap_c,
  output      logic [2:0]                           ok_mask,
  output      logic [1:0]                           rebuilt_phase,
  output      logic                                 frame_ok,
  output      logic [1:0]                           guard_action,
  output      logic [pcrg_pkg::TOTAL_W-1:0]         invalid_frames
);

  pcrg_pkg::cfg_t    cfg;
  pcrg_pkg::frame_t  wr_frame;
  pcrg_pkg::frame_t  rd_frame;
  logic              push;
  logic              q_full;
  logic              q_not_empty;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blanking  <= '0;
      cfg.oc_max    <= pcrg_pkg::RUN_W'(1);
      cfg.inv_limit <= pcrg_pkg::RUN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        pcrg_pkg::REG_BLANKING:  cfg.blanking  <= cfg_data;
        pcrg_pkg::REG_OC_LIMIT:  cfg.oc_max    <= cfg_data;
        pcrg_pkg::REG_INV_LIMIT: cfg.inv_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  pcrg_front u_front (
    .blanking    (cfg.blanking),
    .duty_a      (duty_a),
    .duty_b      (duty_b),
    .duty_c      (duty_c),
    .sample_time (sample_time),
    .sample_a    (sample_a),
    .sample_b    (sample_b),
    .sample_c    (sample_c),
    .overcurrent (overcurrent),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .push        (push),
    .q_full      (q_full),
    .frame       (wr_frame)
  );

  pcrg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_frame  (wr_frame),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .rd_frame  (rd_frame)
  );

  pcrg_guard u_guard (
    .clk            (clk),
    .rst            (rst),
    .oc_max         (cfg.oc_max),
    .inv_limit      (cfg.inv_limit),
    .q_not_empty    (q_not_empty),
    .q_frame        (rd_frame),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .current_a      (current_a),
    .current_b      (current_b),
    .current_c      (current_c),
    .edge_gap_a     (edge_gap_a),
    .edge_gap_b     (edge_gap_b),
    .edge_gap_c     (edge_gap_c),
    .ok_mask        (ok_mask),
    .rebuilt_phase  (rebuilt_phase),
    .frame_ok       (frame_ok),
    .guard_action   (guard_action),
    .invalid_frames (invalid_frames)
  );

endmodule

`default_nettype wire

FILE: rtl/pcrg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcrg_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic signed [pcrg_pkg::CUR_W-1:0]    current_a,
  input  wire logic signed [pcrg_pkg::CUR_W-1:0]    current_b,
  input  wire logic signed [pcrg_pkg::CUR_W-1:0]    current_c,
  input  wire logic [1:0]                           rebuilt_phase,
  input  wire logic                                 frame_ok,
  input  wire logic [1:0]                           guard_action
);

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_a) && $stable(current_b)
      && $stable(current_c) && $stable(guard_action))
    else $error("result word changed while stalled");

  // rebuilt currents of a good frame sum to zero
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> pcrg_pkg::CUR_W'(current_a + current_b + current_c) == '0)
    else $error("phase currents do not sum to zero");

  // a bad frame carries no currents and no rebuilt phase
  a_bad_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> current_a == '0 && current_b == '0 && current_c == '0
      && rebuilt_phase == pcrg_pkg::PH_NONE
      && (guard_action == pcrg_pkg::ACT_HOLD || guard_action == pcrg_pkg::ACT_TRIP_INVALID))
    else $error("bad frame word inconsistent");

  // a good frame names the rebuilt phase and never holds
  a_good_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> rebuilt_phase != pcrg_pkg::PH_NONE
      && (guard_action == pcrg_pkg::ACT_USE || guard_action == pcrg_pkg::ACT_TRIP_OC))
    else $error("good frame word inconsistent");

endmodule

bind phase_current_rebuild_guard_unit pcrg_checker u_pcrg_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .current_a     (current_a),
  .current_b     (current_b),
  .current_c     (current_c),
  .rebuilt_phase (rebuilt_phase),
  .frame_ok      (frame_ok),
  .guard_action  (guard_action)
);

`default_nettype wire

FILE: dv/phase_current_rebuild_guard_unit_tb.sv
`timescale 1ns / 1ps

module phase_current_rebuild_guard_unit_tb;

  localparam logic [pcrg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 140;
  localparam int EXT = pcrg_pkg::CUR_W - pcrg_pkg::RAW_W;

  typedef struct packed {
    logic [pcrg_pkg::TICK_W-1:0]       duty_a;
    logic [pcrg_pkg::TICK_W-1:0]       duty_b;
    logic [pcrg_pkg::TICK_W-1:0]       duty_c;
    logic [pcrg_pkg::TICK_W-1:0]       sample_time;
    logic signed [pcrg_pkg::RAW_W-1:0] sample_a;
    logic signed [pcrg_pkg::RAW_W-1:0] sample_b;
    logic signed [pcrg_pkg::RAW_W-1:0] sample_c;
    logic                              overcurrent;
  } pwm_frame_t;

  typedef struct packed {
    logic signed [pcrg_pkg::CUR_W-1:0] current_a;
    logic signed [pcrg_pkg::CUR_W-1:0] current_b;
    logic signed [pcrg_pkg::CUR_W-1:0] current_c;
    logic [pcrg_pkg::TICK_W-1:0]       edge_gap_a;
    logic [pcrg_pkg::TICK_W-1:0]       edge_gap_b;
    logic [pcrg_pkg::TICK_W-1:0]       edge_gap_c;
    logic [2:0]                        ok_mask;
    pcrg_pkg::phase_t                  rebuilt_phase;
    logic                              frame_ok;
    pcrg_pkg::action_t                 guard_action;
    logic [pcrg_pkg::TOTAL_W-1:0]      invalid_frames;
  } phase_result_t;

  typedef struct {
    bit            reconf;
    logic [15:0]   blank;
    logic [15:0]   oc_lim;
    logic [15:0]   inv_lim;
    pwm_frame_t    stim;
    bit            typed;
    phase_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [pcrg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pcrg_pkg::RUN_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [pcrg_pkg::TICK_W-1:0] duty_a, duty_b, duty_c, sample_time;
  logic signed [pcrg_pkg::RAW_W-1:0] sample_a, sample_b, sample_c;
  logic overcurrent;
  logic out_valid;
  logic out_ready;
  logic signed [pcrg_pkg::CUR_W-1:0] current_a, current_b, current_c;
  logic [pcrg_pkg::TICK_W-1:0] edge_gap_a, edge_gap_b, edge_gap_c;
  logic [2:0] ok_mask;
  logic [1:0] rebuilt_phase;
  logic frame_ok;
  logic [1:0] guard_action;
  logic [pcrg_pkg::TOTAL_W-1:0] invalid_frames;

  // shadow of the register file and the guard counters
  logic [pcrg_pkg::TICK_W-1:0] blank_cfg = '0;
  logic [pcrg_pkg::RUN_W-1:0] oc_max_cfg = 16'd1;
  logic [pcrg_pkg::RUN_W-1:0] inv_limit_cfg = 16'd1;
  logic [pcrg_pkg::RUN_W-1:0] overcurrent_streak = '0;
  logic [pcrg_pkg::RUN_W-1:0] invalid_streak = '0;
  logic [pcrg_pkg::TOTAL_W-1:0] bad_total = '0;

  phase_result_t awaited_frames[$];
  directed_row_t rows[$];
  int mismatches = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_request = 1'b0;
  int hold_cycles = 0;

  phase_current_rebuild_guard_unit u_dut (.*);

  always #10 clk = ~clk;

  function automatic logic [pcrg_pkg::TICK_W-1:0] tick_gap(
      logic [pcrg_pkg::TICK_W-1:0] tick, logic [pcrg_pkg::TICK_W-1:0] duty);
    return (tick > duty) ? tick - duty : '0;
  endfunction

  function automatic phase_result_t rebuild_frame(pwm_frame_t f);
    phase_result_t r;
    logic signed [pcrg_pkg::CUR_W-1:0] ia, ib, ic;
    logic [pcrg_pkg::TICK_W-1:0] least;
    int ok_count;
    r = '0;
    r.edge_gap_a = tick_gap(f.sample_time, f.duty_a);
    r.edge_gap_b = tick_gap(f.sample_time, f.duty_b);
    r.edge_gap_c = tick_gap(f.sample_time, f.duty_c);
    r.ok_mask = {r.edge_gap_c >= blank_cfg, r.edge_gap_b >= blank_cfg,
                 r.edge_gap_a >= blank_cfg};
    ok_count = int'(r.ok_mask[0]) + int'(r.ok_mask[1]) + int'(r.ok_mask[2]);
    r.frame_ok = (ok_count >= 2);
    r.rebuilt_phase = pcrg_pkg::PH_NONE;
    if (ok_count == 2) begin
      if (!r.ok_mask[0]) r.rebuilt_phase = pcrg_pkg::PH_A;
      else if (!r.ok_mask[1]) r.rebuilt_phase = pcrg_pkg::PH_B;
      else r.rebuilt_phase = pcrg_pkg::PH_C;
    end else if (ok_count == 3) begin
      // ties go to C, then B
      least = r.edge_gap_c;
      r.rebuilt_phase = pcrg_pkg::PH_C;
      if (r.edge_gap_b < least) begin
        least = r.edge_gap_b;
        r.rebuilt_phase = pcrg_pkg::PH_B;
      end
      if (r.edge_gap_a < least) r.rebuilt_phase = pcrg_pkg::PH_A;
    end
    ia = {{EXT{f.sample_a[pcrg_pkg::RAW_W-1]}}, f.sample_a};
    ib = {{EXT{f.sample_b[pcrg_pkg::RAW_W-1]}}, f.sample_b};
    ic = {{EXT{f.sample_c[pcrg_pkg::RAW_W-1]}}, f.sample_c};
    if (!r.frame_ok) begin
      ia = '0;
      ib = '0;
      ic = '0;
    end else if (r.rebuilt_phase == pcrg_pkg::PH_A) begin
      ia = -(ib + ic);
    end else if (r.rebuilt_phase == pcrg_pkg::PH_B) begin
      ib = -(ia + ic);
    end else begin
      ic = -(ia + ib);
    end
    r.current_a = ia;
    r.current_b = ib;
    r.current_c = ic;
    if (!r.frame_ok) begin
      overcurrent_streak = '0;
      bad_total = bad_total + 1;
      if (invalid_streak != '1) invalid_streak = invalid_streak + 1;
      if (invalid_streak >= inv_limit_cfg) r.guard_action = pcrg_pkg::ACT_TRIP_INVALID;
      else r.guard_action = pcrg_pkg::ACT_HOLD;
    end else begin
      invalid_streak = '0;
      r.guard_action = pcrg_pkg::ACT_USE;
      if (!f.overcurrent) begin
        overcurrent_streak = '0;
      end else begin
        if (overcurrent_streak != '1) overcurrent_streak = overcurrent_streak + 1;
        if (overcurrent_streak >= oc_max_cfg) r.guard_action = pcrg_pkg::ACT_TRIP_OC;
      end
    end
    r.invalid_frames = bad_total;
    return r;
  endfunction

  function automatic pwm_frame_t frm(int da, int db, int dc, int tk,
                                     int sa, int sb, int sc, bit oc);
    pwm_frame_t f;
    f.duty_a = 16'(da);
    f.duty_b = 16'(db);
    f.duty_c = 16'(dc);
    f.sample_time = 16'(tk);
    f.sample_a = 16'(sa);
    f.sample_b = 16'(sb);
    f.sample_c = 16'(sc);
    f.overcurrent = oc;
    return f;
  endfunction

  function automatic phase_result_t res(int ca, int cb, int cc, int ma, int mb, int mc,
                                        logic [2:0] mask, pcrg_pkg::phase_t ph, bit ok,
                                        pcrg_pkg::action_t act, int unsigned total);
    phase_result_t r;
    r.current_a = 18'(ca);
    r.current_b = 18'(cb);
    r.current_c = 18'(cc);
    r.edge_gap_a = 16'(ma);
    r.edge_gap_b = 16'(mb);
    r.edge_gap_c = 16'(mc);
    r.ok_mask = mask;
    r.rebuilt_phase = ph;
    r.frame_ok = ok;
    r.guard_action = act;
    r.invalid_frames = total;
    return r;
  endfunction

  function automatic void add_row(bit reconf, int blank, int oc_lim, int inv_lim,
                                  pwm_frame_t stim, bit typed, phase_result_t want);
    directed_row_t row;
    row.reconf = reconf;
    row.blank = 16'(blank);
    row.oc_lim = 16'(oc_lim);
    row.inv_lim = 16'(inv_lim);
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    rows.push_back(row);
  endfunction

  function automatic logic [15:0] pick_duty(int tick, bit make_invalid);
    int d;
    if (make_invalid) begin
      d = tick - int'(blank_cfg) + 1 + int'($urandom_range(0, 300));
    end else begin
      case ($urandom_range(0, 5))
        0: d = int'($urandom_range(0, 65535));
        1: d = tick - int'(blank_cfg) + int'($urandom_range(0, 6)) - 3;
        2: d = tick + int'($urandom_range(0, 50));
        default: d = tick - int'(blank_cfg) - int'($urandom_range(0, 400));
      endcase
    end
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pwm_frame_t random_frame(bit make_invalid, bit oc);
    pwm_frame_t f;
    int tick;
    int spare;
    if (make_invalid || $urandom_range(0, 7) == 0) tick = int'($urandom_range(0, 65535));
    else tick = int'($urandom_range(int'(blank_cfg), 65535));
    // in a broken frame at least two phases fall inside the blanking window
    spare = make_invalid ? int'($urandom_range(0, 3)) : -1;
    f.duty_a = pick_duty(tick, make_invalid && spare != 0);
    f.duty_b = pick_duty(tick, make_invalid && spare != 1);
    f.duty_c = pick_duty(tick, make_invalid && spare != 2);
    f.sample_time = tick[15:0];
    f.sample_a = pick_sample();
    f.sample_b = pick_sample();
    f.sample_c = pick_sample();
    f.overcurrent = oc;
    return f;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hffff;
      default: return 16'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [15:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic write_reg(input logic [pcrg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcrg_pkg::RUN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pcrg_pkg::REG_BLANKING: blank_cfg = val;
      pcrg_pkg::REG_OC_LIMIT: oc_max_cfg = val;
      pcrg_pkg::REG_INV_LIMIT: inv_limit_cfg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] blank, input logic [15:0] oc_lim,
                           input logic [15:0] inv_lim);
    write_reg(pcrg_pkg::REG_BLANKING, blank);
    write_reg(REG_UNMAPPED, 16'($urandom));
    write_reg(pcrg_pkg::REG_OC_LIMIT, oc_lim);
    write_reg(pcrg_pkg::REG_INV_LIMIT, inv_lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input pwm_frame_t f, input bit typed, input phase_result_t want);
    phase_result_t predicted;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    duty_a <= f.duty_a;
    duty_b <= f.duty_b;
    duty_c <= f.duty_c;
    sample_time <= f.sample_time;
    sample_a <= f.sample_a;
    sample_b <= f.sample_b;
    sample_c <= f.sample_c;
    overcurrent <= f.overcurrent;
    do @(posedge clk); while (!in_ready);
    predicted = rebuild_frame(f);
    awaited_frames.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_frames.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void compare_field(string name, longint exp, longint act);
    if (exp != act)
      note_mismatch($sformatf("%s expected %0d, got %0d", name, exp, act));
  endfunction

  always @(posedge clk) begin : result_check
    phase_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_frames.size() == 0) begin
        note_mismatch("result word with nothing outstanding");
      end else begin
        want = awaited_frames.pop_front();
        compare_field("current_a", want.current_a, current_a);
        compare_field("current_b", want.current_b, current_b);
        compare_field("current_c", want.current_c, current_c);
        compare_field("edge_gap_a", want.edge_gap_a, edge_gap_a);
        compare_field("edge_gap_b", want.edge_gap_b, edge_gap_b);
        compare_field("edge_gap_c", want.edge_gap_c, edge_gap_c);
        compare_field("ok_mask", want.ok_mask, ok_mask);
        compare_field("rebuilt_phase", want.rebuilt_phase, rebuilt_phase);
        compare_field("frame_ok", want.frame_ok, frame_ok);
        compare_field("guard_action", want.guard_action, guard_action);
        compare_field("invalid_frames", want.invalid_frames, invalid_frames);
      end
    end
  end

  initial begin : ready_driver
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    pwm_frame_t f;
    int invalid_left;
    bit oc_level;
    invalid_left = 0;
    oc_level = 1'b0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    duty_a <= '0;
    duty_b <= '0;
    duty_c <= '0;
    sample_time <= '0;
    sample_a <= '0;
    sample_b <= '0;
    sample_c <= '0;
    overcurrent <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero blanking, both limits one
    add_row(0, 0, 0, 0, frm(0, 0, 0, 0, 0, 0, 0, 0), 1,
            res(0, 0, 0, 0, 0, 0, 3'b111, pcrg_pkg::PH_C, 1, pcrg_pkg::ACT_USE, 0));
    add_row(0, 0, 0, 0, frm(0, 0, 0, 65535, 32767, 32767, -32768, 0), 1,
            res(32767, 32767, -65534, 65535, 65535, 65535, 3'b111, pcrg_pkg::PH_C, 1,
                pcrg_pkg::ACT_USE, 0));
    add_row(0, 0, 0, 0, frm(0, 0, 0, 65535, -32768, -32768, 32767, 0), 1,
            res(-32768, -32768, 65536, 65535, 65535, 65535, 3'b111, pcrg_pkg::PH_C, 1,
                pcrg_pkg::ACT_USE, 0));
    add_row(0, 0, 0, 0, frm(50, 50, 10, 100, 100, 7, 200, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(90, 20, 30, 100, -5, 1234, -32768, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(65535, 40000, 1, 0, 300, -300, 32767, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(0, 0, 0, 0, 0, 0, 0, 1), 1,
            res(0, 0, 0, 0, 0, 0, 3'b111, pcrg_pkg::PH_C, 1, pcrg_pkg::ACT_TRIP_OC, 0));
    // widest blanking: only a full-period margin counts
    add_row(1, 65535, 65535, 65535, frm(0, 0, 0, 65535, 1000, -2000, 3000, 1), 0, '0);
    add_row(0, 0, 0, 0, frm(1, 0, 0, 65535, 12, 34, 56, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(0, 1, 0, 65535, -12, 34, -56, 1), 0, '0);
    add_row(0, 0, 0, 0, frm(0, 0, 1, 65535, 32767, -32768, 0, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(0, 1, 1, 65535, 111, 222, 333, 1), 1,
            res(0, 0, 0, 65535, 65534, 65534, 3'b001, pcrg_pkg::PH_NONE, 0,
                pcrg_pkg::ACT_HOLD, 1));
    add_row(0, 0, 0, 0, frm(0, 0, 0, 0, -1, -1, -1, 0), 0, '0);
    // zero limits trip at once
    add_row(1, 1000, 0, 0, frm(0, 0, 0, 500, 5, 6, 7, 1), 1,
            res(0, 0, 0, 500, 500, 500, 3'b000, pcrg_pkg::PH_NONE, 0,
                pcrg_pkg::ACT_TRIP_INVALID, 3));
    add_row(0, 0, 0, 0, frm(0, 0, 0, 5000, 9, -9, 4, 1), 0, '0);
    add_row(0, 0, 0, 0, frm(0, 0, 0, 5000, 9, -9, 4, 0), 0, '0);
    // runs below and at a limit of three, margins on the blanking edge
    add_row(1, 1000, 3, 3, frm(0, 1, 1, 1000, 1, 2, 3, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(65535, 65535, 65535, 1000, 4, 5, 6, 1), 0, '0);
    add_row(0, 0, 0, 0, frm(0, 1, 1, 1000, 7, 8, 9, 0), 0, '0);
    add_row(0, 0, 0, 0, frm(999, 1000, 0, 1999, 100, 200, 300, 1), 0, '0);
    add_row(0, 0, 0, 0, frm(999, 1000, 0, 1999, -100, 200, -300, 1), 0, '0);
    add_row(0, 0, 0, 0, frm(999, 1000, 0, 1999, 32767, 32767, 1, 1), 0, '0);

    foreach (rows[i]) begin
      if (rows[i].reconf) begin
        drain();
        configure(rows[i].blank, rows[i].oc_lim, rows[i].inv_lim);
      end
      send_frame(rows[i].stim, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(pick_blank(), pick_limit(), pick_limit());
      send_idle = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      recv_idle = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 4) begin
        send_idle = 1'b0;
        hold_cycles = $urandom_range(60, 120);
        hold_request = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (invalid_left == 0 && blank_cfg != 0 && $urandom_range(0, 11) == 0)
          invalid_left = $urandom_range(1, 8);
        if ($urandom_range(0, 4) == 0) oc_level = ~oc_level;
        f = random_frame(invalid_left != 0, oc_level);
        if (invalid_left != 0) invalid_left--;
        send_frame(f, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
